// ----- hdl/isec_pkg.sv -----
// Package for the interval set engine: operation codes, defaults, and the
// command/status bundles between controller and datapath. No dependencies.
package isec_pkg;

   localparam int MAX_INTERVALS_DEF = 16;
   localparam int VALUE_WIDTH_DEF   = 32;
   localparam int TOL_W             = 31;
   localparam int MODE_W            = 3;

   // operation codes carried in req_tuser
   localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SUB     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POINT   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SPAN    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ISECT   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd5;

   // csr register indexes
   localparam logic CSR_QUERY_TOL = 1'b0;
   localparam logic CSR_ISECT_TOL = 1'b1;

   typedef struct packed {
      logic accept;  // latch a new operation
      logic rd;      // read the entry at the scan index
      logic proc;    // process the last entry read
      logic fin;     // commit the result beat and store changes
   } cmd_type;

   typedef struct packed {
      logic scan_done; // no entry left to scan
      logic hold;      // current entry needs another process step
      logic out_free;  // result register can take a beat
   } stat_type;

endpackage

// ----- hdl/interval_set_engine_core.sv -----
// Top level of the interval set engine: stream ports, csr port, controller
// and datapath. Depends on isec_pkg, isec_ctrl, isec_datapath.
//
//  channel | direction | beat contents
//  req_    | in        | tdata {endpoint_b, endpoint_a}, tuser {edge_mode, mode}
//  rsp_    | out       | tdata {count, piece_valid, piece_high, piece_low, hit, status}
//  csr_    | in        | write enable, register index, 31-bit data
//
// Each stored entry costs a store read step and a process step on the single
// read port; add repeats the process step when leaving the copy phase and when
// inserting the new piece, subtract repeats it for each entry that is split.
// Reset is synchronous: the set is empty and both tolerances are zero.
// A stalled rsp_ side holds the scan only when an intersect piece or the
// final beat cannot be placed; a new req_ beat is taken while the last
// result beat still waits.
module interval_set_engine_core
   import isec_pkg::*;
#(
   parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
   parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
   localparam int CNTW   = $clog2(MAX_INTERVALS + 1),
   localparam int REQ_DW = ((2*VALUE_WIDTH + 7) / 8) * 8,
   localparam int RSP_BW = 3 + 2*VALUE_WIDTH + CNTW,
   localparam int RSP_DW = ((RSP_BW + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,  // endpoint_a, endpoint_b, zero fill
   input  logic [3:0]        req_tuser,  // mode[2:0], edge_mode
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,  // status, hit, piece_low, piece_high,
                                         // piece_valid, interval_count, zero fill
   output logic              rsp_tlast,
   input  logic              csr_we,
   input  logic              csr_addr,
   input  logic [TOL_W-1:0]  csr_wdata
);

   localparam int W = VALUE_WIDTH;

   cmd_type  cmd;
   stat_type stat;

   logic                 st, ht, pv;
   logic signed [W-1:0]  plow, phigh;
   logic [CNTW-1:0]      cnt;

   isec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   isec_datapath #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .VALUE_WIDTH   (VALUE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_mode    (req_tuser[2:0]),
      .in_a       ($signed(req_tdata[W-1:0])),
      .in_b       ($signed(req_tdata[2*W-1:W])),
      .in_edge    (req_tuser[3]),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (st),
      .out_hit    (ht),
      .out_low    (plow),
      .out_high   (phigh),
      .out_pvalid (pv),
      .out_last   (rsp_tlast),
      .out_count  (cnt)
   );

   // pack the result beat
   assign rsp_tdata = RSP_DW'({cnt, pv, phigh, plow, ht, st});

endmodule

// ----- hdl/isec_ctrl.sv -----
// Sequencer of the interval set engine: accept, scan entries, finish.
// Depends on isec_pkg.
module isec_ctrl
   import isec_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_PROC = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            if (stat.scan_done) begin
               state_in = S_FIN;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_PROC;
            end
         end
         S_PROC: begin
            cmd.proc = 1'b1;
            if (!stat.hold) state_in = S_READ;
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.fin  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ----- hdl/isec_datapath.sv -----
// Datapath of the interval set engine: ping-pong interval store, operand
// registers, tolerance compares and the result register. Depends on isec_pkg.
module isec_datapath
   import isec_pkg::*;
#(
   parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
   parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
   localparam int CNTW = $clog2(MAX_INTERVALS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output stat_type                      stat,
   input  logic [MODE_W-1:0]             in_mode,
   input  logic signed [VALUE_WIDTH-1:0] in_a,
   input  logic signed [VALUE_WIDTH-1:0] in_b,
   input  logic                          in_edge,
   input  logic                          csr_we,
   input  logic                          csr_addr,
   input  logic [TOL_W-1:0]              csr_wdata,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          out_status,
   output logic                          out_hit,
   output logic signed [VALUE_WIDTH-1:0] out_low,
   output logic signed [VALUE_WIDTH-1:0] out_high,
   output logic                          out_pvalid,
   output logic                          out_last,
   output logic [CNTW-1:0]               out_count
);

   localparam int W   = VALUE_WIDTH;
   localparam int IW  = $clog2(MAX_INTERVALS);
   localparam int CW  = ((W > TOL_W) ? W : TOL_W) + 2;
   localparam logic [CNTW-1:0] MAXC = CNTW'(MAX_INTERVALS);

   typedef logic signed [W-1:0]  val_type;
   typedef logic signed [CW-1:0] wide_type;

   function automatic wide_type ext(input val_type x);
      ext = CW'(x);
   endfunction

   function automatic wide_type add_tol(input val_type x, input logic [TOL_W-1:0] t);
      add_tol = CW'(x) + $signed(CW'(t));
   endfunction

   // store: two banks, one write and one read port
   val_type lo_mem [2**(IW+1)];
   val_type hi_mem [2**(IW+1)];

   logic [TOL_W-1:0]  qtol_ff, itol_ff;
   logic [MODE_W-1:0] mode_ff;
   logic              edge_ff;
   val_type           a_ff, lo_ff, lo_in, hi_ff, hi_in;
   logic              cur_ff, cur_in;
   logic [CNTW-1:0]   count_ff, count_in, idx_ff, idx_in, nout_ff, nout_in;
   logic [1:0]        phase_ff, phase_in;
   logic              merged_ff, merged_in, second_ff, second_in;
   logic              status_ff, status_in, hit_ff, hit_in, have_ff, have_in;
   val_type           pl_ff, pl_in, ph_ff, ph_in;
   val_type           rd_lo_ff, rd_hi_ff;

   logic              rvalid_ff, rvalid_in;
   logic              rstatus_ff, rstatus_in, rhit_ff, rhit_in;
   val_type           rlow_ff, rlow_in, rhigh_ff, rhigh_in;
   logic              rpv_ff, rpv_in, rlast_ff, rlast_in;
   logic [CNTW-1:0]   rcount_ff, rcount_in;

   logic              wr_want, wr_en, hold, advance, out_free, load;
   val_type           wr_lo, wr_hi, ql, qh;
   logic              keep;

   assign out_free = !rvalid_ff || out_ready;

   assign stat.scan_done = (idx_ff == count_ff) || (mode_ff > MODE_ISECT);
   assign stat.hold      = hold;
   assign stat.out_free  = out_free;

   // intersect window tests
   always_comb begin
      if (edge_ff) begin
         keep = !(add_tol(hi_ff, itol_ff) < ext(rd_lo_ff)) &&
                !(add_tol(rd_hi_ff, itol_ff) < ext(lo_ff));
      end else begin
         keep = !(add_tol(rd_lo_ff, itol_ff) > ext(hi_ff)) &&
                !(add_tol(lo_ff, itol_ff) > ext(rd_hi_ff));
      end
      ql = (lo_ff > rd_lo_ff) ? lo_ff : rd_lo_ff;
      qh = (hi_ff < rd_hi_ff) ? hi_ff : rd_hi_ff;
   end

   // per-entry processing and operation control
   always_comb begin
      lo_in = lo_ff;  hi_in = hi_ff;  cur_in = cur_ff;  count_in = count_ff;
      idx_in = idx_ff;  nout_in = nout_ff;  phase_in = phase_ff;
      merged_in = merged_ff;  second_in = second_ff;  status_in = status_ff;
      hit_in = hit_ff;  have_in = have_ff;  pl_in = pl_ff;  ph_in = ph_ff;
      rvalid_in = rvalid_ff && !out_ready;
      rstatus_in = rstatus_ff;  rhit_in = rhit_ff;  rlow_in = rlow_ff;
      rhigh_in = rhigh_ff;  rpv_in = rpv_ff;  rlast_in = rlast_ff;
      rcount_in = rcount_ff;
      wr_want = 1'b0;  wr_lo = rd_lo_ff;  wr_hi = rd_hi_ff;
      hold = 1'b0;  advance = 1'b0;  load = 1'b0;

      if (cmd.accept) begin
         lo_in = (in_a < in_b) ? in_a : in_b;
         hi_in = (in_a < in_b) ? in_b : in_a;
         idx_in = '0;  nout_in = '0;  phase_in = 2'd0;  merged_in = 1'b0;
         second_in = 1'b0;  status_in = 1'b0;  hit_in = 1'b0;  have_in = 1'b0;
      end

      if (cmd.proc) begin
         unique case (mode_ff)
            MODE_ADD: begin
               unique case (phase_ff)
                  2'd0: begin
                     if (rd_hi_ff < lo_ff) begin
                        wr_want = 1'b1;  advance = 1'b1;
                     end else begin
                        phase_in = 2'd1;  hold = 1'b1;
                     end
                  end
                  2'd1: begin
                     if (rd_lo_ff <= hi_ff) begin
                        if (rd_lo_ff < lo_ff) lo_in = rd_lo_ff;
                        if (rd_hi_ff > hi_ff) hi_in = rd_hi_ff;
                        merged_in = 1'b1;  advance = 1'b1;
                     end else if (!merged_ff && count_ff >= MAXC) begin
                        // store full and nothing merged: end the scan, drop the piece
                        idx_in = count_ff;
                     end else begin
                        wr_want = 1'b1;  wr_lo = lo_ff;  wr_hi = hi_ff;
                        phase_in = 2'd2;  hold = 1'b1;
                     end
                  end
                  default: begin
                     wr_want = 1'b1;  advance = 1'b1;
                  end
               endcase
            end
            MODE_SUB: begin
               if (rd_hi_ff < lo_ff || rd_lo_ff > hi_ff) begin
                  wr_want = 1'b1;  advance = 1'b1;
               end else if (!second_ff) begin
                  // keep the left part, queue the right part
                  if (rd_lo_ff < lo_ff) begin
                     wr_want = 1'b1;  wr_hi = lo_ff;
                  end
                  if (hi_ff < rd_hi_ff) begin
                     second_in = 1'b1;  hold = 1'b1;
                  end else begin
                     advance = 1'b1;
                  end
               end else begin
                  wr_want = 1'b1;  wr_lo = hi_ff;
                  second_in = 1'b0;  advance = 1'b1;
               end
            end
            MODE_POINT: begin
               if (add_tol(a_ff, qtol_ff) > ext(rd_lo_ff) &&
                   add_tol(rd_hi_ff, qtol_ff) > ext(a_ff)) hit_in = 1'b1;
               advance = 1'b1;
            end
            MODE_SPAN: begin
               if (add_tol(lo_ff, qtol_ff) > ext(rd_lo_ff) &&
                   add_tol(rd_hi_ff, qtol_ff) > ext(hi_ff)) hit_in = 1'b1;
               advance = 1'b1;
            end
            MODE_ISECT: begin
               if (!keep) begin
                  advance = 1'b1;
               end else if (have_ff && ql <= ph_ff) begin
                  if (qh > ph_ff) ph_in = qh;
                  advance = 1'b1;
               end else if (have_ff) begin
                  // emit the finished piece before starting a new one
                  if (!out_free) begin
                     hold = 1'b1;
                  end else begin
                     load = 1'b1;
                     rstatus_in = 1'b0;  rhit_in = 1'b1;  rlow_in = pl_ff;
                     rhigh_in = ph_ff;  rpv_in = 1'b1;  rlast_in = 1'b0;
                     rcount_in = count_ff;
                     pl_in = ql;  ph_in = qh;  advance = 1'b1;
                  end
               end else begin
                  pl_in = ql;  ph_in = qh;  have_in = 1'b1;  advance = 1'b1;
               end
            end
            default: advance = 1'b1;
         endcase
      end

      if (cmd.fin) begin
         load = 1'b1;
         rstatus_in = 1'b0;  rhit_in = hit_ff;  rlow_in = '0;  rhigh_in = '0;
         rpv_in = 1'b0;  rlast_in = 1'b1;
         unique case (mode_ff)
            MODE_ADD: begin
               if (phase_ff == 2'd2) begin
                  cur_in = !cur_ff;  count_in = nout_ff;
               end else if (!merged_ff && count_ff >= MAXC) begin
                  rstatus_in = 1'b1;
               end else begin
                  wr_want = 1'b1;  wr_lo = lo_ff;  wr_hi = hi_ff;
                  cur_in = !cur_ff;  count_in = nout_ff + 1'b1;
               end
            end
            MODE_SUB: begin
               rstatus_in = status_ff;
               cur_in = !cur_ff;  count_in = nout_ff;
            end
            MODE_ISECT: begin
               rhit_in = have_ff;  rpv_in = have_ff;
               rlow_in = have_ff ? pl_ff : '0;
               rhigh_in = have_ff ? ph_ff : '0;
            end
            MODE_CLEAR: count_in = '0;
            default: rhit_in = hit_ff;
         endcase
         rcount_in = count_in;
      end

      // write guard: a full bank drops the piece
      wr_en = wr_want && (nout_ff < MAXC);
      if (wr_en) nout_in = nout_ff + 1'b1;
      if (wr_want && !wr_en && mode_ff == MODE_SUB) status_in = 1'b1;
      if (advance) idx_in = idx_ff + 1'b1;
      if (load) rvalid_in = 1'b1;
   end

   // store write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         lo_mem[{!cur_ff, nout_ff[IW-1:0]}] <= wr_lo;
         hi_mem[{!cur_ff, nout_ff[IW-1:0]}] <= wr_hi;
      end
      if (cmd.rd) begin
         rd_lo_ff <= lo_mem[{cur_ff, idx_ff[IW-1:0]}];
         rd_hi_ff <= hi_mem[{cur_ff, idx_ff[IW-1:0]}];
      end
   end

   // operand capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= in_mode;
         edge_ff <= in_edge;
         a_ff    <= in_a;
      end
      lo_ff <= lo_in;  hi_ff <= hi_in;  idx_ff <= idx_in;  nout_ff <= nout_in;
      phase_ff <= phase_in;  merged_ff <= merged_in;  second_ff <= second_in;
      status_ff <= status_in;  hit_ff <= hit_in;  have_ff <= have_in;
      pl_ff <= pl_in;  ph_ff <= ph_in;
      rstatus_ff <= rstatus_in;  rhit_ff <= rhit_in;  rlow_ff <= rlow_in;
      rhigh_ff <= rhigh_in;  rpv_ff <= rpv_in;  rlast_ff <= rlast_in;
      rcount_ff <= rcount_in;
   end

   // control state and tolerances
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= 1'b0;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
         qtol_ff   <= '0;
         itol_ff   <= '0;
      end else begin
         cur_ff    <= cur_in;
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
         if (csr_we && csr_addr == CSR_QUERY_TOL) qtol_ff <= csr_wdata;
         if (csr_we && csr_addr == CSR_ISECT_TOL) itol_ff <= csr_wdata;
      end
   end

   assign out_valid  = rvalid_ff;
   assign out_status = rstatus_ff;
   assign out_hit    = rhit_ff;
   assign out_low    = rlow_ff;
   assign out_high   = rhigh_ff;
   assign out_pvalid = rpv_ff;
   assign out_last   = rlast_ff;
   assign out_count  = rcount_ff;

endmodule

// ----- hdl/isec_checker.sv -----
// Port-level checks for interval_set_engine_core, bound to the top level.
// Depends on isec_pkg.
module isec_checker
   import isec_pkg::*;
#(
   parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
   parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
   localparam int CNTW   = $clog2(MAX_INTERVALS + 1),
   localparam int RSP_BW = 3 + 2*VALUE_WIDTH + CNTW,
   localparam int RSP_DW = ((RSP_BW + 7) / 8) * 8
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_DW-1:0] rsp_tdata,
   input logic              rsp_tlast
);

   localparam int PV = 2 + 2*VALUE_WIDTH;

   logic [CNTW-1:0] cnt;
   assign cnt = rsp_tdata[RSP_BW-1:PV+1];

   // hold a stalled beat
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cnt <= CNTW'(MAX_INTERVALS))
      else $error("interval count above capacity");

   a_piece_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[PV] |-> rsp_tdata[1] && !rsp_tdata[0])
      else $error("piece without hit or with overflow");

   a_mid_piece: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[PV])
      else $error("non-final beat without a piece");

endmodule

bind interval_set_engine_core isec_checker #(
   .MAX_INTERVALS (MAX_INTERVALS),
   .VALUE_WIDTH   (VALUE_WIDTH)
) u_isec_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ----- bench/tb.sv -----
// Self-checking bench for interval_set_engine_core: streams random and directed
// set operations, predicts every result beat, compares in order. Needs isec_pkg.
`timescale 1ns / 100ps

module tb
   import isec_pkg::*;
();

   localparam int NMAX = 16;
   localparam int RSP_DW = 72;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic              edge_sel;
      logic [2:0]        mode;
      logic signed [31:0] ep_b;
      logic signed [31:0] ep_a;
   } op_type;

   typedef struct packed {
      logic [4:0]         count;
      logic               piece_valid;
      logic signed [31:0] piece_high;
      logic signed [31:0] piece_low;
      logic               hit;
      logic               status;
      logic               last;
   } beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [63:0]       req_tdata = '0;
   logic [3:0]        req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;
   logic              rsp_tlast;
   logic              csr_we = 1'b0;
   logic              csr_addr = 1'b0;
   logic [TOL_W-1:0]  csr_wdata = '0;

   interval_set_engine_core dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   longint set_lo[NMAX];
   longint set_hi[NMAX];
   int     set_n = 0;
   longint qtol = 0, itol = 0;

   op_type    pending_ops[$];
   beat_type  expected_beats[$];
   int     errors = 0;
   bit     sender_hold = 0;
   int     idle_cycles = 0;

   function automatic beat_type mk(bit st, bit h, longint lo, longint hi, bit v, bit l);
      beat_type b;
      b.status = st; b.hit = h; b.piece_low = lo[31:0]; b.piece_high = hi[31:0];
      b.piece_valid = v; b.last = l; b.count = set_n[4:0];
      return b;
   endfunction

   // apply one operation to the model set and queue the beats it yields
   task automatic predict_op(op_type op);
      longint a, b, lo, hi, el, eh, ql, qh;
      longint nl[NMAX], nh[NMAX], pl[NMAX], ph[NMAX];
      int n, i, merged;
      bit st, h;
      a = op.ep_a; b = op.ep_b;
      lo = (a < b) ? a : b; hi = (a < b) ? b : a;
      st = 0; h = 0; n = 0;
      case (op.mode)
         MODE_ADD: begin
            i = 0; merged = 0;
            while (i < set_n && set_hi[i] < lo) begin
               nl[n] = set_lo[i]; nh[n] = set_hi[i]; n++; i++;
            end
            while (i < set_n && set_lo[i] <= hi) begin
               if (set_lo[i] < lo) lo = set_lo[i];
               if (set_hi[i] > hi) hi = set_hi[i];
               merged++; i++;
            end
            if (merged == 0 && set_n >= NMAX) st = 1;
            else begin
               nl[n] = lo; nh[n] = hi; n++;
               while (i < set_n) begin
                  nl[n] = set_lo[i]; nh[n] = set_hi[i]; n++; i++;
               end
               for (i = 0; i < n; i++) begin set_lo[i] = nl[i]; set_hi[i] = nh[i]; end
               set_n = n;
            end
         end
         MODE_SUB: begin
            for (i = 0; i < set_n; i++) begin
               el = set_lo[i]; eh = set_hi[i];
               if (eh < lo || el > hi) begin
                  if (n < NMAX) begin nl[n] = el; nh[n] = eh; n++; end else st = 1;
               end else begin
                  if (el < lo) begin
                     if (n < NMAX) begin nl[n] = el; nh[n] = lo; n++; end else st = 1;
                  end
                  if (hi < eh) begin
                     if (n < NMAX) begin nl[n] = hi; nh[n] = eh; n++; end else st = 1;
                  end
               end
            end
            for (i = 0; i < n; i++) begin set_lo[i] = nl[i]; set_hi[i] = nh[i]; end
            set_n = n;
         end
         MODE_POINT: begin
            for (i = 0; i < set_n; i++)
               if (a + qtol > set_lo[i] && set_hi[i] + qtol > a) h = 1;
         end
         MODE_SPAN: begin
            for (i = 0; i < set_n; i++)
               if (lo + qtol > set_lo[i] && set_hi[i] + qtol > hi) h = 1;
         end
         MODE_ISECT: begin
            for (i = 0; i < set_n; i++) begin
               el = set_lo[i]; eh = set_hi[i];
               if (op.edge_sel) begin
                  if (hi + itol < el || eh + itol < lo) continue;
               end else begin
                  if (el + itol > hi || lo + itol > eh) continue;
               end
               ql = (lo > el) ? lo : el;
               qh = (hi < eh) ? hi : eh;
               if (n > 0 && ql <= ph[n-1]) begin
                  if (qh > ph[n-1]) ph[n-1] = qh;
               end else begin
                  pl[n] = ql; ph[n] = qh; n++;
               end
            end
            if (n == 0) expected_beats.push_back(mk(0, 0, 0, 0, 0, 1));
            for (i = 0; i < n; i++)
               expected_beats.push_back(mk(0, 1, pl[i], ph[i], 1, i + 1 == n));
            return;
         end
         MODE_CLEAR: set_n = 0;
         default: ;
      endcase
      expected_beats.push_back(mk(st, h, 0, 0, 0, 1));
   endtask

   // driver: present queued ops with random gaps
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_op(pending_ops.pop_front());
            send_gap = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) send_gap = 0;
         end
         if ((req_tvalid && req_tready) || !req_tvalid) begin
            if (send_gap > 0 || sender_hold || pending_ops.size() == 0) begin
               req_tvalid <= 1'b0;
               if (send_gap > 0) send_gap--;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= {pending_ops[0].ep_b, pending_ops[0].ep_a};
               req_tuser  <= {pending_ops[0].edge_sel, pending_ops[0].mode};
            end
         end
      end
   end

   // monitor: check each result beat and stall at random
   int recv_gap = 0;
   beat_type got, want;
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[0]; got.hit = rsp_tdata[1];
            got.piece_low = rsp_tdata[33:2]; got.piece_high = rsp_tdata[65:34];
            got.piece_valid = rsp_tdata[66]; got.count = rsp_tdata[71:67];
            got.last = rsp_tlast;
            if (expected_beats.size() == 0) begin
               $error("unexpected result beat %h", rsp_tdata);
               errors++;
            end else begin
               want = expected_beats.pop_front();
               if (got.status != want.status) begin
                  $error("status exp %0d got %0d", want.status, got.status); errors++;
               end
               if (got.hit != want.hit) begin
                  $error("hit exp %0d got %0d", want.hit, got.hit); errors++;
               end
               if (got.piece_low != want.piece_low) begin
                  $error("piece_low exp %0d got %0d", want.piece_low, got.piece_low);
                  errors++;
               end
               if (got.piece_high != want.piece_high) begin
                  $error("piece_high exp %0d got %0d", want.piece_high, got.piece_high);
                  errors++;
               end
               if (got.piece_valid != want.piece_valid) begin
                  $error("piece_valid exp %0d got %0d", want.piece_valid, got.piece_valid);
                  errors++;
               end
               if (got.last != want.last) begin
                  $error("last exp %0d got %0d", want.last, got.last); errors++;
               end
               if (got.count != want.count) begin
                  $error("interval_count exp %0d got %0d", want.count, got.count);
                  errors++;
               end
            end
            recv_gap = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) recv_gap = 0;
         end
         if (recv_gap > 0) begin
            rsp_tready <= 1'b0;
            recv_gap--;
         end else rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles with neither a request accept nor a result beat
   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic op_type mk_op(int md, longint a, longint b, bit e);
      op_type o;
      o.mode = md[2:0]; o.ep_a = a[31:0]; o.ep_b = b[31:0]; o.edge_sel = e;
      return o;
   endfunction

   // small values on a coarse grid so the set fills, merges and splits
   function automatic longint grid_val();
      return (longint'($urandom_range(0, 64)) - 32) * 65536 * 4
             + (($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 131071)) : 0);
   endfunction

   function automatic op_type rand_op();
      op_type o;
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) begin
         o.mode = 3'($urandom); o.ep_a = $urandom; o.ep_b = $urandom;
         o.edge_sel = 1'($urandom);
      end else begin
         o.mode = (r < 35) ? MODE_ADD : (r < 50) ? MODE_SUB : (r < 62) ? MODE_POINT :
                  (r < 74) ? MODE_SPAN : (r < 95) ? MODE_ISECT : MODE_CLEAR;
         o.ep_a = 32'(grid_val()); o.ep_b = 32'(grid_val()); o.edge_sel = 1'($urandom);
      end
      return o;
   endfunction

   task automatic wait_drained();
      while (pending_ops.size() != 0 || req_tvalid || expected_beats.size() != 0)
         @(posedge clock);
      repeat (2 * NMAX + 10) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, longint val);
      @(posedge clock);
      csr_we <= 1'b1; csr_addr <= idx; csr_wdata <= val[TOL_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_QUERY_TOL) qtol = val & 64'h7FFFFFFF;
      else itol = val & 64'h7FFFFFFF;
   endtask

   localparam longint VMAX = 64'sd2147483647;
   localparam longint VMIN = -64'sd2147483648;

   initial begin
      int ph, k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, backward endpoints, touching merge, split, overflow
      pending_ops.push_back(mk_op(MODE_ISECT, 0, 10, 0));
      pending_ops.push_back(mk_op(MODE_ADD, VMAX, VMIN, 0));
      pending_ops.push_back(mk_op(MODE_POINT, VMIN, 0, 0));
      pending_ops.push_back(mk_op(MODE_SPAN, VMIN, VMAX, 0));
      pending_ops.push_back(mk_op(MODE_SUB, 100, -100, 0));
      pending_ops.push_back(mk_op(MODE_ISECT, VMIN, VMAX, 1));
      pending_ops.push_back(mk_op(MODE_CLEAR, 0, 0, 0));
      pending_ops.push_back(mk_op(MODE_ADD, 0, 65536, 0));
      pending_ops.push_back(mk_op(MODE_ADD, 65536, 131072, 0));
      pending_ops.push_back(mk_op(MODE_SUB, 0, 131072, 0));
      pending_ops.push_back(mk_op(6, 5, 6, 1));
      pending_ops.push_back(mk_op(7, -1, -1, 0));
      pending_ops.push_back(mk_op(MODE_CLEAR, 0, 0, 0));
      for (k = 0; k < 16; k++) pending_ops.push_back(mk_op(MODE_ADD, k*1000, k*1000+10, 0));
      pending_ops.push_back(mk_op(MODE_ADD, 99000, 99010, 0));
      pending_ops.push_back(mk_op(MODE_ADD, -5000, -4990, 0));
      pending_ops.push_back(mk_op(MODE_SUB, 3002, 3005, 0));
      pending_ops.push_back(mk_op(MODE_ISECT, 0, 20000, 1));
      wait_drained();

      // random phases over several tolerance settings
      for (ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin csr_write(CSR_QUERY_TOL, 0); csr_write(CSR_ISECT_TOL, 0); end
            1: begin csr_write(CSR_QUERY_TOL, 64'h7FFFFFFF);
                     csr_write(CSR_ISECT_TOL, 64'h7FFFFFFF); end
            2: begin csr_write(CSR_QUERY_TOL, 65536); csr_write(CSR_ISECT_TOL, 131072); end
            default: begin csr_write(CSR_QUERY_TOL, $urandom_range(0, 1 << 20));
                           csr_write(CSR_ISECT_TOL, $urandom); end
         endcase
         for (k = 0; k < 44; k++) pending_ops.push_back(rand_op());
         if (ph == 2) begin
            // hold the sender until every result is back
            while (pending_ops.size() > 22) @(posedge clock);
            sender_hold = 1;
            while (req_tvalid || expected_beats.size() != 0) @(posedge clock);
            sender_hold = 0;
         end
         wait_drained();
      end

      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
